[sv/rar_pkg.sv]
// ----------------------------------------------------------------------------
// rar_pkg
// shared operation codes and the per-word flag bundle passed from the front
// end to the reduction engine
// ----------------------------------------------------------------------------
package rar_pkg;

  // operation codes on func
  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_SUB = 2'd1;
  localparam logic [1:0] FUNC_MUL = 2'd2;
  localparam logic [1:0] FUNC_DIV = 2'd3;

  // classification of a raw fraction
  typedef struct packed {
    logic div_zero;  // raw denominator is zero
    logic num_zero;  // raw numerator is zero
    logic neg;       // numerator and denominator signs differ
  } rar_flags_t;

  localparam int FLAGS_W = $bits(rar_flags_t);

endpackage

[sv/rar_front.sv]
// ----------------------------------------------------------------------------
// rar_front
// accepts a command word, forms the raw numerator and denominator with one
// shared multiplier, classifies them and pushes magnitudes plus flags
// ----------------------------------------------------------------------------
module rar_front import rar_pkg::*; #(
  parameter int OPERAND_WIDTH = 16,
  parameter int PW            = 2 * OPERAND_WIDTH,
  parameter int GW            = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      func,
  input  logic signed [OPERAND_WIDTH-1:0] num_a,
  input  logic signed [OPERAND_WIDTH-1:0] den_a,
  input  logic signed [OPERAND_WIDTH-1:0] num_b,
  input  logic signed [OPERAND_WIDTH-1:0] den_b,
  input  logic                            q_full,
  output logic                            q_push,
  output rar_flags_t                      q_flags,
  output logic [GW-1:0]                   q_mn,
  output logic [GW-1:0]                   q_md
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_M0   = 3'd1;
  localparam logic [2:0] F_M1   = 3'd2;
  localparam logic [2:0] F_M2   = 3'd3;
  localparam logic [2:0] F_SUM  = 3'd4;
  localparam logic [2:0] F_PUSH = 3'd5;

  logic [2:0]                      state;
  logic [1:0]                      op;
  logic signed [OPERAND_WIDTH-1:0] an, ad, bn, bd;
  logic signed [OPERAND_WIDTH-1:0] mul_x, mul_y;
  logic signed [PW-1:0]            prod;
  logic signed [PW-1:0]            p0, p1, dr;
  logic signed [GW-1:0]            n;
  logic [GW-1:0]                   n_mag;
  logic [PW-1:0]                   d_mag;

  assign busy = (state != F_IDLE);

  // operand routing to the shared multiplier
  always_comb begin
    mul_x = an;
    mul_y = bd;
    case (state)
      F_M0: begin
        mul_x = an;
        mul_y = (op == FUNC_MUL) ? bn : bd;
      end
      F_M1: begin
        mul_x = bn;
        mul_y = ad;
      end
      F_M2: begin
        mul_x = ad;
        mul_y = (op == FUNC_DIV) ? bn : bd;
      end
      default: begin
        mul_x = an;
        mul_y = bd;
      end
    endcase
  end

  assign prod  = PW'(mul_x) * PW'(mul_y);
  assign n_mag = n[GW-1] ? (GW'(0) - GW'(n)) : GW'(n);
  assign d_mag = dr[PW-1] ? (PW'(0) - PW'(dr)) : PW'(dr);

  assign q_push           = (state == F_PUSH) && !q_full;
  assign q_flags.div_zero = (dr == '0);
  assign q_flags.num_zero = (n == '0);
  assign q_flags.neg      = n[GW-1] ^ dr[PW-1];
  assign q_mn             = n_mag;
  assign q_md             = GW'(d_mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: if (start) state <= F_M0;
        F_M0:   state <= F_M1;
        F_M1:   state <= F_M2;
        F_M2:   state <= F_SUM;
        F_SUM:  state <= F_PUSH;
        F_PUSH: if (!q_full) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && start) begin
      op <= func;
      an <= num_a;
      ad <= den_a;
      bn <= num_b;
      bd <= den_b;
    end
    if (state == F_M0) p0 <= prod;
    if (state == F_M1) p1 <= prod;
    if (state == F_M2) dr <= prod;
    if (state == F_SUM) begin
      case (op)
        FUNC_ADD: n <= GW'(p0) + GW'(p1);
        FUNC_SUB: n <= GW'(p0) - GW'(p1);
        default:  n <= GW'(p0);
      endcase
    end
  end

endmodule

[sv/rar_queue.sv]
// ----------------------------------------------------------------------------
// rar_queue
// short first-in first-out buffer between the front end and the reduction
// engine
// ----------------------------------------------------------------------------
module rar_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] din,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] dout,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     wr_ptr, rd_ptr;
  logic [AW:0]       count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("queue count beyond depth");

endmodule

[sv/rar_back.sv]
// ----------------------------------------------------------------------------
// rar_back
// reduction engine: binary gcd of the magnitudes, then two-lane restoring
// division by the gcd, then sign and width formatting of the result word
// ----------------------------------------------------------------------------
module rar_back import rar_pkg::*; #(
  parameter int GW = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  output logic               q_pop,
  input  rar_flags_t         q_flags,
  input  logic [GW-1:0]      q_mn,
  input  logic [GW-1:0]      q_md,
  output logic               done,
  output logic signed [32:0] res_num,
  output logic [30:0]        res_den,
  output logic               div_zero
);

  localparam int KW = $clog2(GW + 1);
  localparam int CW = $clog2(GW);
  localparam int XW = (GW > 33) ? GW : 33;
  localparam int YW = (GW > 31) ? GW : 31;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_GCD  = 2'd1;
  localparam logic [1:0] B_DIV  = 2'd2;
  localparam logic [1:0] B_FIN  = 2'd3;

  logic [1:0]    state;
  logic [GW-1:0] a, b, g;
  logic [KW-1:0] k;
  logic [GW-1:0] mn_r, md_r;
  logic          neg_r;
  logic [GW:0]   diff_ab, diff_ba;
  logic [GW-1:0] rem_n, rem_d, dq_n, dq_d;
  logic [CW-1:0] cnt;
  logic [GW:0]   tn, td, sn, sd;
  logic [XW-1:0] num_ext;
  logic [YW-1:0] den_ext;

  assign q_pop   = (state == B_IDLE) && !q_empty;
  assign diff_ab = {1'b0, a} - {1'b0, b};
  assign diff_ba = {1'b0, b} - {1'b0, a};

  // one restoring step per lane
  assign tn = {rem_n, dq_n[GW-1]};
  assign td = {rem_d, dq_d[GW-1]};
  assign sn = tn - {1'b0, g};
  assign sd = td - {1'b0, g};

  assign num_ext = neg_r ? (XW'(0) - XW'(dq_n)) : XW'(dq_n);
  assign den_ext = YW'(dq_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            if (q_flags.div_zero || q_flags.num_zero) begin
              done <= 1'b1;
            end else begin
              state <= B_GCD;
            end
          end
        end
        B_GCD: begin
          if (a[0] && b[0] && diff_ab == '0) state <= B_DIV;
        end
        B_DIV: begin
          if (cnt == CW'(GW - 1)) state <= B_FIN;
        end
        B_FIN: begin
          done  <= 1'b1;
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          a     <= q_mn;
          b     <= q_md;
          k     <= '0;
          mn_r  <= q_mn;
          md_r  <= q_md;
          neg_r <= q_flags.neg;
          if (q_flags.div_zero) begin
            res_num  <= '0;
            res_den  <= '0;
            div_zero <= 1'b1;
          end else if (q_flags.num_zero) begin
            res_num  <= '0;
            res_den  <= 31'd1;
            div_zero <= 1'b0;
          end
        end
      end
      B_GCD: begin
        if (!a[0] && !b[0]) begin
          a <= a >> 1;
          b <= b >> 1;
          k <= k + 1'b1;
        end else if (!a[0]) begin
          a <= a >> 1;
        end else if (!b[0]) begin
          b <= b >> 1;
        end else if (diff_ab == '0) begin
          g     <= a << k;
          rem_n <= '0;
          rem_d <= '0;
          dq_n  <= mn_r;
          dq_d  <= md_r;
          cnt   <= '0;
        end else if (diff_ab[GW]) begin
          b <= diff_ba[GW:1];
        end else begin
          a <= diff_ab[GW:1];
        end
      end
      B_DIV: begin
        cnt <= cnt + 1'b1;
        if (!sn[GW]) begin
          rem_n <= sn[GW-1:0];
          dq_n  <= {dq_n[GW-2:0], 1'b1};
        end else begin
          rem_n <= tn[GW-1:0];
          dq_n  <= {dq_n[GW-2:0], 1'b0};
        end
        if (!sd[GW]) begin
          rem_d <= sd[GW-1:0];
          dq_d  <= {dq_d[GW-2:0], 1'b1};
        end else begin
          rem_d <= td[GW-1:0];
          dq_d  <= {dq_d[GW-2:0], 1'b0};
        end
      end
      B_FIN: begin
        res_num  <= num_ext[32:0];
        res_den  <= den_ext[30:0];
        div_zero <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == B_GCD) |-> (a != '0 && b != '0))
    else $error("gcd operand reached zero");

  a_rem_below_g: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV) |-> (rem_n < g && rem_d < g))
    else $error("division remainder not below divisor");

  a_err_den: assert property (@(posedge clk) disable iff (rst)
    done |-> (div_zero == (res_den == '0)))
    else $error("error flag and denominator disagree");

endmodule

[sv/rational_arithmetic_reduce_top.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_reduce_top
// signed fraction add, subtract, multiply and divide with gcd reduction
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; one result word comes
// back per command, on res_num / res_den / div_zero for the single cycle in
// which done is high. The receiver cannot stall, so done must be sampled
// whenever it rises. busy is high while the front end forms the raw
// fraction (three products on one shared multiplier, the sum, then
// classification), plus any wait for room in the 2-word queue. Results
// come back in command order. The reduction engine takes a new word only
// from its idle state. A zero numerator or zero denominator is answered
// straight from that state; otherwise the engine loads the word, runs a
// binary gcd, then restoring division by the gcd (both quotients at once),
// then formats the result. Internal width GW = min(2*OPERAND_WIDTH+1, 64);
// at the default width that is 33. A zero raw denominator gives div_zero
// with 0/0; a zero raw numerator gives 0/1. Otherwise the denominator is
// positive and the numerator carries the sign. Raw values wrap at 64 bits
// when OPERAND_WIDTH is 32. No clearing pass after reset.
// ----------------------------------------------------------------------------
module rational_arithmetic_reduce_top import rar_pkg::*; #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      func,
  input  logic signed [OPERAND_WIDTH-1:0] num_a,
  input  logic signed [OPERAND_WIDTH-1:0] den_a,
  input  logic signed [OPERAND_WIDTH-1:0] num_b,
  input  logic signed [OPERAND_WIDTH-1:0] den_b,
  output logic                            done,
  output logic signed [32:0]              res_num,
  output logic [30:0]                     res_den,
  output logic                            div_zero
);

  // product width and raw numerator width (sum of two products, 64-bit wrap)
  localparam int PW = 2 * OPERAND_WIDTH;
  localparam int GW = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1;
  localparam int QW = FLAGS_W + 2 * GW;

  // front end to queue
  logic          f_push;
  rar_flags_t    f_flags;
  logic [GW-1:0] f_mn, f_md;

  // queue to reduction engine
  logic          q_full, q_empty, q_pop;
  logic [QW-1:0] q_dout;
  rar_flags_t    q_flags;
  logic [GW-1:0] q_mn, q_md;

  assign q_flags = rar_flags_t'(q_dout[QW-1 -: FLAGS_W]);
  assign q_mn    = q_dout[2*GW-1 -: GW];
  assign q_md    = q_dout[GW-1:0];

  // cross-multiply and classify
  rar_front #(
    .OPERAND_WIDTH (OPERAND_WIDTH),
    .PW            (PW),
    .GW            (GW)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .func    (func),
    .num_a   (num_a),
    .den_a   (den_a),
    .num_b   (num_b),
    .den_b   (den_b),
    .q_full  (q_full),
    .q_push  (f_push),
    .q_flags (f_flags),
    .q_mn    (f_mn),
    .q_md    (f_md)
  );

  // decouples the fixed-length front end from the variable-length reduction
  rar_queue #(
    .DATA_W (QW),
    .DEPTH  (2)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   ({f_flags, f_mn, f_md}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // gcd, divide and format
  rar_back #(
    .GW (GW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_flags  (q_flags),
    .q_mn     (q_mn),
    .q_md     (q_md),
    .done     (done),
    .res_num  (res_num),
    .res_den  (res_den),
    .div_zero (div_zero)
  );

endmodule
